@@ hw/rtl/lfu_pkg.sv @@
package lfu_pkg;

    localparam int SET_INDEX_W = 11;
    localparam int WAY_INDEX_W = 4;
    localparam int VALID_MASK_W = 16;

    localparam int NUM_SETS_DEF = 2048;
    localparam int NUM_WAYS_DEF = 16;
    localparam int COUNTER_BITS_DEF = 32;

    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

endpackage

@@ hw/rtl/lfu_if.sv @@
interface lfu_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [lfu_pkg::SET_INDEX_W-1:0]     set_index;
    logic [lfu_pkg::WAY_INDEX_W-1:0]     way_index;
    logic                                hit_flag;
    logic [lfu_pkg::VALID_MASK_W-1:0]    valid_mask;

    modport source (output valid, kind, set_index, way_index, hit_flag, valid_mask,
                    input ready);
    modport sink (input valid, kind, set_index, way_index, hit_flag, valid_mask,
                  output ready);
endinterface

interface lfu_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lfu_pkg::WAY_INDEX_W-1:0]     victim_way;
    logic                                victim_was_invalid;

    modport source (output valid, victim_way, victim_was_invalid, input ready);
    modport sink (input valid, victim_way, victim_was_invalid, output ready);
endinterface

@@ hw/rtl/lfu_ram.sv @@
module lfu_ram #(
    parameter int WIDTH = lfu_pkg::NUM_WAYS_DEF * lfu_pkg::COUNTER_BITS_DEF,
    parameter int DEPTH = lfu_pkg::NUM_SETS_DEF,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hw/rtl/lfu_cache_replacement.sv @@
// Least-frequently-used replacement state for a set-associative cache. Each set keeps one
// counter per way in one row of a memory. A victim request reads its set's row and a single
// comparator then walks the ways one per cycle, stopping at the first invalid way or at the
// last way, and the result appears as the block becomes ready again. The walk waits at the way
// where it stops while an earlier result has not been taken. An update is a read-modify-write
// of the row; an update whose way index is NUM_WAYS or more is dropped. When NUM_SETS is below
// 2048 and not a power of two, the set index is first reduced by a reciprocal multiplication,
// in the states S_MOD and S_FOLD. After reset the memory is cleared one row per cycle, so no
// request is accepted until every row has been cleared.
module lfu_cache_replacement #(
    parameter int NUM_SETS = lfu_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = lfu_pkg::NUM_WAYS_DEF,
    parameter int COUNTER_BITS = lfu_pkg::COUNTER_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lfu_req_if.sink  i_req,
    lfu_rsp_if.source o_rsp
);

    localparam int SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WayW = $clog2(NUM_WAYS);
    localparam int RowW = NUM_WAYS * COUNTER_BITS;
    localparam bit SetPow2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam bit ModNeeded = !SetPow2 && (NUM_SETS < 2048);
    localparam logic [SetW-1:0] SetMask = SetW'(NUM_SETS - 1);
    localparam logic [SetW-1:0] SetLast = SetW'(NUM_SETS - 1);
    localparam logic [WayW-1:0] WayLast = WayW'(NUM_WAYS - 1);
    localparam int SidxW = lfu_pkg::SET_INDEX_W;
    localparam int ProdW = 2 * SidxW + 2;
    localparam int SetDivShift = SidxW + SetW;
    localparam logic [SidxW+1:0] SetRecip =
        (SidxW + 2)'(((1 << SetDivShift) + NUM_SETS - 1) / NUM_SETS);
    localparam logic [SidxW-1:0] SetCount = SidxW'(NUM_SETS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_FOLD  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [SetW-1:0] r_clr, n_clr;
    logic [SetW-1:0] r_set, n_set;
    logic [SidxW-1:0] r_quot, n_quot;
    logic [WayW-1:0] r_way, n_way;
    logic [WayW-1:0] r_best_way, n_best_way;
    logic [COUNTER_BITS-1:0] r_best_val, n_best_val;
    logic r_kind, n_kind;
    logic r_hit, n_hit;
    logic [lfu_pkg::VALID_MASK_W-1:0] r_mask, n_mask;
    logic [lfu_pkg::SET_INDEX_W-1:0] r_sidx, n_sidx;
    logic r_out_valid, n_out_valid;
    logic [lfu_pkg::WAY_INDEX_W-1:0] r_out_way, n_out_way;
    logic r_out_inv, n_out_inv;

    logic ram_we, ram_re;
    logic [SetW-1:0] ram_waddr;
    logic [RowW-1:0] ram_wdata, ram_rdata, row_new;
    logic [COUNTER_BITS-1:0] cur_ctr, upd_ctr;
    logic [ProdW-1:0] quot_prod;
    logic [SidxW-1:0] quot;
    logic [SidxW-1:0] rem_val;
    logic [31:0] mask_ext;
    logic way_valid, better, out_free;

    lfu_ram #(
        .WIDTH(RowW),
        .DEPTH(NUM_SETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_set),
        .o_rdata(ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.victim_way = r_out_way;
    assign o_rsp.victim_was_invalid = r_out_inv;

    always_comb begin
        cur_ctr = ram_rdata[r_way*COUNTER_BITS +: COUNTER_BITS];
        if (!r_hit) begin
            upd_ctr = COUNTER_BITS'(1);
        end else if (cur_ctr == '1) begin
            upd_ctr = cur_ctr;
        end else begin
            upd_ctr = cur_ctr + COUNTER_BITS'(1);
        end
        row_new = ram_rdata;
        row_new[r_way*COUNTER_BITS +: COUNTER_BITS] = upd_ctr;
        quot_prod = ProdW'(r_sidx) * ProdW'(SetRecip);
        quot = SidxW'(quot_prod >> SetDivShift);
        rem_val = r_sidx - r_quot * SetCount;
        mask_ext = 32'(r_mask);
        way_valid = mask_ext[5'(r_way)];
        better = (r_way == '0) || (cur_ctr < r_best_val);
        out_free = !r_out_valid || o_rsp.ready;
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_set = r_set;
        n_quot = r_quot;
        n_way = r_way;
        n_best_way = r_best_way;
        n_best_val = r_best_val;
        n_kind = r_kind;
        n_hit = r_hit;
        n_mask = r_mask;
        n_sidx = r_sidx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_way = r_out_way;
        n_out_inv = r_out_inv;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = r_set;
        ram_wdata = row_new;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == SetLast) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + SetW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind = i_req.kind;
                    n_hit = i_req.hit_flag;
                    n_mask = i_req.valid_mask;
                    n_sidx = i_req.set_index;
                    if (i_req.kind == lfu_pkg::KIND_UPDATE) begin
                        n_way = WayW'(i_req.way_index);
                    end else begin
                        n_way = '0;
                    end
                    if (i_req.kind == lfu_pkg::KIND_UPDATE
                            && 32'(i_req.way_index) >= NUM_WAYS) begin
                        n_state = S_IDLE;
                    end else if (ModNeeded) begin
                        n_state = S_MOD;
                    end else if (SetPow2) begin
                        n_set = SetW'(i_req.set_index) & SetMask;
                        n_state = S_READ;
                    end else begin
                        n_set = SetW'(i_req.set_index);
                        n_state = S_READ;
                    end
                end
            end
            S_MOD: begin
                n_quot = quot;
                n_state = S_FOLD;
            end
            S_FOLD: begin
                n_set = SetW'(rem_val);
                n_state = S_READ;
            end
            S_READ: begin
                ram_re = 1'b1;
                if (r_kind == lfu_pkg::KIND_UPDATE) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WRITE: begin
                ram_we = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (!way_valid) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_way = lfu_pkg::WAY_INDEX_W'(r_way);
                        n_out_inv = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_way == WayLast) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_way = better ? lfu_pkg::WAY_INDEX_W'(r_way)
                                           : lfu_pkg::WAY_INDEX_W'(r_best_way);
                        n_out_inv = 1'b0;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (better) begin
                        n_best_way = r_way;
                        n_best_val = cur_ctr;
                    end
                    n_way = r_way + WayW'(1);
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set <= n_set;
        r_quot <= n_quot;
        r_way <= n_way;
        r_best_way <= n_best_way;
        r_best_val <= n_best_val;
        r_kind <= n_kind;
        r_hit <= n_hit;
        r_mask <= n_mask;
        r_sidx <= n_sidx;
        r_out_way <= n_out_way;
        r_out_inv <= n_out_inv;
    end

endmodule

@@ hw/rtl/lfu_checker.sv @@
module lfu_port_checker #(
    parameter int NUM_WAYS = lfu_pkg::NUM_WAYS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [lfu_pkg::WAY_INDEX_W-1:0]   i_victim_way,
    input logic                              i_victim_was_invalid
);

    // The memory is still being cleared as reset is released.
    a_no_request_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_req_ready)
        else $error("request accepted during the clearing pass");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted while one is in progress");

    a_victim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_victim_way) < NUM_WAYS)
        else $error("victim way beyond the number of ways");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_victim_way) && $stable(i_victim_was_invalid))
        else $error("stalled result changed or dropped");

endmodule

bind lfu_cache_replacement lfu_port_checker #(
    .NUM_WAYS(NUM_WAYS)
) u_lfu_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_victim_way        (o_rsp.victim_way),
    .i_victim_was_invalid(o_rsp.victim_was_invalid)
);

@@ dv/lfu_checker.sv @@
module lfu_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfu_req_if        i_req,
    lfu_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lfu_pkg::COUNTER_BITS_DEF-1:0] COUNT_MAX =
        {lfu_pkg::COUNTER_BITS_DEF{1'b1}};

    typedef struct packed {
        logic [lfu_pkg::WAY_INDEX_W-1:0] way;
        logic                            was_invalid;
    } t_victim_pick;

    logic [lfu_pkg::COUNTER_BITS_DEF-1:0]
        use_count [lfu_pkg::NUM_SETS_DEF][lfu_pkg::NUM_WAYS_DEF];
    t_victim_pick awaited_victims [$];

    function automatic t_victim_pick pick_victim(
            input logic [lfu_pkg::SET_INDEX_W-1:0] set_idx,
            input logic [lfu_pkg::VALID_MASK_W-1:0] mask);
        t_victim_pick                         pick;
        logic [lfu_pkg::COUNTER_BITS_DEF-1:0] lowest;
        int                                   row;
        row = int'(set_idx) % lfu_pkg::NUM_SETS_DEF;
        for (int w = 0; w < lfu_pkg::NUM_WAYS_DEF; w++) begin
            if (w >= lfu_pkg::VALID_MASK_W || !mask[w]) begin
                pick.way = lfu_pkg::WAY_INDEX_W'(w);
                pick.was_invalid = 1'b1;
                return pick;
            end
        end
        pick.way = '0;
        pick.was_invalid = 1'b0;
        lowest = use_count[row][0];
        for (int w = 1; w < lfu_pkg::NUM_WAYS_DEF; w++) begin
            if (use_count[row][w] < lowest) begin
                lowest = use_count[row][w];
                pick.way = lfu_pkg::WAY_INDEX_W'(w);
            end
        end
        return pick;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] lfu_checker: %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_victim_pick want;
        int           row;
        if (!i_rst_n) begin
            foreach (use_count[s, w]) use_count[s][w] = '0;
            awaited_victims.delete();
            o_fail_count = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.kind == lfu_pkg::KIND_UPDATE) begin
                    row = int'(i_req.set_index) % lfu_pkg::NUM_SETS_DEF;
                    if (int'(i_req.way_index) < lfu_pkg::NUM_WAYS_DEF) begin
                        if (i_req.hit_flag) begin
                            if (use_count[row][i_req.way_index] != COUNT_MAX) begin
                                use_count[row][i_req.way_index]++;
                            end
                        end else begin
                            use_count[row][i_req.way_index] =
                                lfu_pkg::COUNTER_BITS_DEF'(1);
                        end
                    end
                end else begin
                    awaited_victims.push_back(pick_victim(i_req.set_index, i_req.valid_mask));
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_victims.size() == 0) begin
                    report_mismatch("response with no victim request waiting",
                                    int'(i_rsp.victim_way), -1);
                end else begin
                    want = awaited_victims.pop_front();
                    if (i_rsp.victim_way !== want.way) begin
                        report_mismatch("victim_way", int'(i_rsp.victim_way), int'(want.way));
                    end
                    if (i_rsp.victim_was_invalid !== want.was_invalid) begin
                        report_mismatch("victim_was_invalid", int'(i_rsp.victim_was_invalid),
                                        int'(want.was_invalid));
                    end
                end
            end
        end
        o_pending = awaited_victims.size();
    end

endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfu_pkg::*;

    localparam logic ACCESS_HIT = 1'b1;
    localparam logic ACCESS_FILL = 1'b0;
    localparam int   RANDOM_REQUESTS = 1000;
    localparam int   DRAIN_CYCLES = NUM_WAYS_DEF + 16;
    localparam int   HOLD_OFF_CYCLES = 400;
    localparam int   HOLD_OFF_AT = 300;
    localparam int   PAUSE_AT = 600;
    localparam int   CALM_FROM = 700;
    localparam int   CALM_TO = 850;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent_count;
    logic calm_stretch;
    logic [SET_INDEX_W-1:0] hot_sets [8];

    lfu_req_if req_if ();
    lfu_rsp_if rsp_if ();

    lfu_cache_replacement u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    lfu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    assign calm_stretch = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

    task automatic send_request(input logic kind, input logic [SET_INDEX_W-1:0] set_idx,
                                input logic [WAY_INDEX_W-1:0] way, input logic hit,
                                input logic [VALID_MASK_W-1:0] mask);
        while (!calm_stretch && $urandom_range(99) < 14) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.set_index  <= set_idx;
        req_if.way_index  <= way;
        req_if.hit_flag   <= hit;
        req_if.valid_mask <= mask;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_random_request();
        logic [SET_INDEX_W-1:0]  set_idx;
        logic [VALID_MASK_W-1:0] mask;
        int                      shape;
        set_idx = ($urandom_range(99) < 80) ? hot_sets[$urandom_range(7)]
                                            : SET_INDEX_W'($urandom);
        if ($urandom_range(1) == 0) begin
            shape = $urandom_range(99);
            if (shape < 60) begin
                mask = '1;
            end else if (shape < 80) begin
                mask = ~(VALID_MASK_W'(1) << $urandom_range(VALID_MASK_W - 1));
            end else begin
                mask = VALID_MASK_W'($urandom);
            end
            send_request(KIND_VICTIM, set_idx, WAY_INDEX_W'($urandom), 1'($urandom), mask);
        end else begin
            send_request(KIND_UPDATE, set_idx, WAY_INDEX_W'($urandom),
                         ($urandom_range(99) < 70) ? ACCESS_HIT : ACCESS_FILL,
                         VALID_MASK_W'($urandom));
        end
    endtask

    // The receiver holds off once for a long stretch so that the request side backs up.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= HOLD_OFF_AT) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= calm_stretch || ($urandom_range(99) >= 14);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        sent_count = 0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_VICTIM;
        req_if.set_index = '0;
        req_if.way_index = '0;
        req_if.hit_flag = ACCESS_FILL;
        req_if.valid_mask = '0;
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        for (int i = 2; i < 8; i++) hot_sets[i] = SET_INDEX_W'($urandom);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(KIND_VICTIM, '0, '0, ACCESS_FILL, 16'h0000);
        send_request(KIND_VICTIM, '1, '1, ACCESS_HIT, 16'h7FFF);
        send_request(KIND_VICTIM, '0, '0, ACCESS_FILL, 16'h5555);
        send_request(KIND_VICTIM, 11'd1024, '1, ACCESS_HIT, 16'h8000);
        send_request(KIND_VICTIM, '0, '0, ACCESS_FILL, 16'hFFFF);
        send_request(KIND_UPDATE, '0, 4'd0, ACCESS_FILL, 16'h0000);
        send_request(KIND_VICTIM, '0, '1, ACCESS_HIT, 16'hFFFF);
        send_request(KIND_UPDATE, '0, 4'd15, ACCESS_HIT, 16'hFFFF);
        send_request(KIND_UPDATE, '0, 4'd15, ACCESS_HIT, 16'h0000);
        send_request(KIND_UPDATE, '0, 4'd1, ACCESS_FILL, 16'hFFFF);
        send_request(KIND_VICTIM, '0, '0, ACCESS_FILL, 16'hFFFF);
        send_request(KIND_UPDATE, '0, 4'd0, ACCESS_HIT, 16'h0000);
        send_request(KIND_UPDATE, '0, 4'd0, ACCESS_HIT, 16'h0000);
        send_request(KIND_UPDATE, '0, 4'd0, ACCESS_FILL, 16'h0000);
        send_request(KIND_VICTIM, '0, '1, ACCESS_HIT, 16'hFFFF);
        send_request(KIND_UPDATE, '1, 4'd15, ACCESS_HIT, 16'h0000);
        send_request(KIND_VICTIM, '1, '0, ACCESS_FILL, 16'h7FFF);
        send_request(KIND_VICTIM, '1, '0, ACCESS_FILL, 16'hFFFF);
        send_request(KIND_UPDATE, '1, 4'd0, ACCESS_HIT, 16'hFFFF);
        send_request(KIND_VICTIM, '1, '1, ACCESS_HIT, 16'hFFFF);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == PAUSE_AT) begin
                req_if.valid <= 1'b0;
                do begin
                    @(negedge i_clk);
                end while (pending != 0);
            end
            send_random_request();
        end
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
